>>> src/uart_transaction_frame_timer_unit_macros.svh
// assertion helpers shared by the frame timer rtl
`ifndef UART_TRANSACTION_FRAME_TIMER_UNIT_MACROS_SVH
`define UART_TRANSACTION_FRAME_TIMER_UNIT_MACROS_SVH

// same-cycle implication
`define UTTF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("uttf assertion failed");

// next-cycle implication
`define UTTF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("uttf assertion failed");

`endif

>>> src/uttf_pkg.sv
`default_nettype none
package uttf_pkg;

    localparam int INPUT_TDATA_W  = 32;
    localparam int OUTPUT_TDATA_W = 48;
    localparam int CFG_INDEX_W    = 8;
    localparam int CFG_DATA_W     = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_RESPONSE_TIMEOUT = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_GAP              = 8'd1;

    localparam logic [15:0] RESPONSE_TIMEOUT_RESET = 16'd1000;
    localparam logic [15:0] GAP_TICKS_RESET        = 16'd10;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_RX     = 3'd1,
        OP_TXDONE = 3'd2,
        OP_SEND   = 3'd3,
        OP_HDONE  = 3'd4,
        OP_READ   = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_WAIT = 3'b010,
        PH_RECV = 3'b100
    } phase_t;

    typedef struct packed {
        logic        busy_res;
        logic        frame_ready;
        logic        timed_out;
        logic [8:0]  byte_count;
        logic [15:0] timeout_total;
        logic        tx_start;
        logic [8:0]  tx_length;
        logic        overflow;
    } ctrl_result_t;

endpackage
`default_nettype wire

>>> src/uttf_ctrl.sv
`default_nettype none
module uttf_ctrl #(
    parameter int BUFFER_BYTES = 256,
    parameter int COUNT_W      = 9
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [uttf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [uttf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic                              accept,
    input  wire uttf_pkg::op_t                     operation,
    input  wire logic [8:0]                        send_length,
    output logic [COUNT_W-1:0]                     count_q,
    output logic                                   store_wr,
    output uttf_pkg::ctrl_result_t                 result
);
    import uttf_pkg::*;

    logic [15:0]        rto_reg, gap_lim_reg;
    phase_t             phase_reg, phase_next;
    logic [15:0]        rt_reg, rt_next, gt_reg, gt_next;
    logic               tp_reg, tp_next, gp_reg, gp_next;
    logic               ready_reg, ready_next, error_reg, error_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [15:0]        total_reg, total_next;
    logic               ovf_reg, ovf_next;
    logic [15:0]        rt_inc, gt_inc;
    logic               started;
    logic [31:0]        len_sat;

    assign rt_inc  = rt_reg + 16'd1;
    assign gt_inc  = gt_reg + 16'd1;
    assign len_sat = (32'(send_length) > BUFFER_BYTES) ? 32'(BUFFER_BYTES)
                                                       : 32'(send_length);

    always_comb begin
        phase_next = phase_reg;
        rt_next    = rt_reg;
        gt_next    = gt_reg;
        tp_next    = tp_reg;
        gp_next    = gp_reg;
        ready_next = ready_reg;
        error_next = error_reg;
        count_next = count_reg;
        total_next = total_reg;
        ovf_next   = ovf_reg;
        started    = 1'b0;
        store_wr   = 1'b0;
        case (operation)
            OP_TICK: begin
                if (phase_reg != PH_IDLE) begin
                    rt_next = rt_inc;
                    if (rt_inc >= rto_reg) begin
                        rt_next = '0;
                        tp_next = 1'b1;
                    end
                end
                if (phase_reg == PH_RECV) begin
                    gt_next = gt_inc;
                    if (gt_inc >= gap_lim_reg) begin
                        gt_next = '0;
                        gp_next = 1'b1;
                    end
                end
                if (phase_reg == PH_RECV && gp_next) begin
                    gp_next    = 1'b0;
                    ready_next = 1'b1;
                    phase_next = PH_IDLE;
                end
                if (phase_reg != PH_IDLE && tp_next) begin
                    total_next = total_reg + 16'd1;
                    ready_next = 1'b1;
                    error_next = 1'b1;
                    count_next = '0;
                    phase_next = PH_IDLE;
                end
            end
            OP_RX: begin
                if (32'(count_reg) < BUFFER_BYTES) begin
                    store_wr   = 1'b1;
                    count_next = count_reg + COUNT_W'(1);
                end else begin
                    ovf_next = 1'b1;
                end
                gt_next    = '0;
                phase_next = PH_RECV;
            end
            OP_TXDONE: begin
                phase_next = PH_WAIT;
            end
            OP_SEND: begin
                if (phase_reg == PH_IDLE) begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                    rt_next    = '0;
                    gt_next    = '0;
                    tp_next    = 1'b0;
                    gp_next    = 1'b0;
                    error_next = 1'b0;
                    ready_next = 1'b0;
                    phase_next = PH_WAIT;
                    started    = 1'b1;
                end
            end
            OP_HDONE: begin
                ready_next = 1'b0;
                phase_next = PH_IDLE;
            end
            OP_READ: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rto_reg     <= RESPONSE_TIMEOUT_RESET;
            gap_lim_reg <= GAP_TICKS_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_index == CFG_IDX_RESPONSE_TIMEOUT) begin
                rto_reg <= cfg_wdata;
            end else if (cfg_index == CFG_IDX_GAP) begin
                gap_lim_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            rt_reg    <= '0;
            gt_reg    <= '0;
            tp_reg    <= 1'b0;
            gp_reg    <= 1'b0;
            ready_reg <= 1'b0;
            error_reg <= 1'b0;
            count_reg <= '0;
            total_reg <= '0;
            ovf_reg   <= 1'b0;
        end else if (accept) begin
            phase_reg <= phase_next;
            rt_reg    <= rt_next;
            gt_reg    <= gt_next;
            tp_reg    <= tp_next;
            gp_reg    <= gp_next;
            ready_reg <= ready_next;
            error_reg <= error_next;
            count_reg <= count_next;
            total_reg <= total_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign count_q = count_reg;

    always_comb begin
        result.busy_res      = (phase_next != PH_IDLE);
        result.frame_ready   = ready_next;
        result.timed_out     = error_next;
        result.byte_count    = 9'(count_next);
        result.timeout_total = total_next;
        result.tx_start      = started;
        result.tx_length     = started ? 9'(len_sat) : 9'd0;
        result.overflow      = ovf_next;
    end

endmodule
`default_nettype wire

>>> src/uart_transaction_frame_timer_unit.sv
// an input transfer's result is registered in the p stage and then in the output register before it is offered
// throughput: one item per cycle while the output is not stalled; a stalled result still lets one more item in
// the control state updates at the input transfer, the store read is registered
// reset clears phase, timers, flags, counters and limits to 1000 and 10 ticks
// receive store contents are not cleared; only entries below byte_count are read
`default_nettype none
`include "uart_transaction_frame_timer_unit_macros.svh"
module uart_transaction_frame_timer_unit #(
    parameter int BUFFER_BYTES = 256
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [uttf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [uttf_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // operation[2:0], data_byte[10:3], send_length[19:11], read_index[27:20]
    input  wire logic [uttf_pkg::INPUT_TDATA_W-1:0]   s_tdata,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // busy_res[0], frame_ready[1], timed_out[2], byte_count[11:3],
    // timeout_total[27:12], tx_start[28], tx_length[37:29], read_data[45:38],
    // overflow[46]
    output logic [uttf_pkg::OUTPUT_TDATA_W-1:0]       m_tdata
);
    import uttf_pkg::*;

    localparam int ADDR_W  = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
    localparam int COUNT_W = $clog2(BUFFER_BYTES + 1);

    logic               accept;
    op_t                in_op;
    logic [7:0]         in_byte;
    logic [8:0]         in_len;
    logic [7:0]         in_idx;
    logic [COUNT_W-1:0] count_q;
    logic               store_wr;
    ctrl_result_t       ctrl_res;
    logic               rd_en;

    logic [7:0]         store_mem [BUFFER_BYTES];
    logic [7:0]         rd_q_reg;

    logic               p_valid_reg;
    ctrl_result_t       p_res_reg;
    logic               p_rd_en_reg;
    logic               p_advance;

    logic               out_valid_reg;
    logic [OUTPUT_TDATA_W-1:0] out_data_reg;
    logic [7:0]         p_read_data;

    assign in_op   = op_t'(s_tdata[2:0]);
    assign in_byte = s_tdata[10:3];
    assign in_len  = s_tdata[19:11];
    assign in_idx  = s_tdata[27:20];

    assign p_advance = p_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !p_valid_reg || p_advance;
    assign accept    = s_tvalid && s_tready;

    uttf_ctrl #(
        .BUFFER_BYTES(BUFFER_BYTES),
        .COUNT_W     (COUNT_W)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .accept     (accept),
        .operation  (in_op),
        .send_length(in_len),
        .count_q    (count_q),
        .store_wr   (store_wr),
        .result     (ctrl_res)
    );

    assign rd_en = (in_op == OP_READ) && (32'(in_idx) < 32'(count_q))
                   && (32'(in_idx) < BUFFER_BYTES);

    always_ff @(posedge aclk) begin
        if (accept && store_wr) begin
            store_mem[count_q[ADDR_W-1:0]] <= in_byte;
        end
        if (accept) begin
            rd_q_reg <= store_mem[ADDR_W'(in_idx)];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (accept) begin
            p_valid_reg <= 1'b1;
        end else if (p_advance) begin
            p_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p_res_reg   <= ctrl_res;
            p_rd_en_reg <= rd_en;
        end
    end

    assign p_read_data = p_rd_en_reg ? rd_q_reg : 8'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (p_advance) begin
            out_data_reg <= {1'b0,
                             p_res_reg.overflow,
                             p_read_data,
                             p_res_reg.tx_length,
                             p_res_reg.tx_start,
                             p_res_reg.timeout_total,
                             p_res_reg.byte_count,
                             p_res_reg.timed_out,
                             p_res_reg.frame_ready,
                             p_res_reg.busy_res};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `UTTF_ASSERT_NOW(a_full_blocks_input, aclk, aresetn,
        p_valid_reg && out_valid_reg && !m_tready, !s_tready)
    `UTTF_ASSERT_NEXT(a_accept_fills_stage, aclk, aresetn,
        accept, p_valid_reg)
    `UTTF_ASSERT_NOW(a_start_means_busy, aclk, aresetn,
        m_tvalid && m_tdata[28], m_tdata[0] && (32'(m_tdata[37:29]) <= BUFFER_BYTES))

endmodule
`default_nettype wire
